// ----- rtl/depth_hue_colorizer_unit_macros.svh -----
// assertion helpers for the depth hue colorizer
`ifndef DEPTH_HUE_COLORIZER_UNIT_MACROS_SVH
`define DEPTH_HUE_COLORIZER_UNIT_MACROS_SVH

// same-cycle implication, ignored while reset is high
`define DHC_ASSERT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, ignored while reset is high
`define DHC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/dhc_pkg.sv -----
package dhc_pkg;

  localparam int DEPTH_BITS = 24;
  localparam int HUE_BITS   = 11;
  localparam int HUE_MAX    = 1529;
  localparam int RAMP       = 255;
  localparam int REM_BITS   = DEPTH_BITS + HUE_BITS;
  localparam int DIV_CELLS  = HUE_BITS;
  localparam int ADDR_BITS  = 3;
  localparam int DATA_BITS  = 32;

  typedef enum logic {
    REG_MIN_DEPTH = 1'b0,
    REG_MAX_DEPTH = 1'b1
  } reg_idx_t;

  // one beat moving down the divider chain
  typedef struct packed {
    logic [REM_BITS-1:0] rem;
    logic [REM_BITS-1:0] dvs;
    logic [HUE_BITS-1:0] quo;
  } div_beat_t;

endpackage

// ----- rtl/dhc_front.sv -----
module dhc_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [dhc_pkg::DEPTH_BITS-1:0] min_depth,
  input  logic [dhc_pkg::DEPTH_BITS-1:0] max_depth,
  input  logic                           depth_valid,
  input  logic [dhc_pkg::DEPTH_BITS-1:0] depth,
  output logic                           depth_stall,
  output logic                           beat_valid,
  output dhc_pkg::div_beat_t             beat,
  input  logic                           beat_hold
);
  import dhc_pkg::*;

  logic                  a_valid;
  logic [DEPTH_BITS-1:0] a_span;
  logic [DEPTH_BITS-1:0] a_offset;
  logic                  a_hold;
  logic                  b_hold;
  logic [DEPTH_BITS:0]   min_plus;
  logic [DEPTH_BITS-1:0] span;
  logic [DEPTH_BITS-1:0] diff;
  logic [DEPTH_BITS-1:0] offset;

  always_comb begin
    min_plus = {1'b0, min_depth} + {{DEPTH_BITS{1'b0}}, 1'b1};
    if ({1'b0, max_depth} > min_plus) begin
      span = max_depth - min_depth;
    end else begin
      span = DEPTH_BITS'(1);
    end
    diff = depth - min_depth;
    if (depth > min_depth) begin
      offset = (diff > span) ? span : diff;
    end else begin
      offset = '0;
    end
  end

  assign b_hold      = beat_valid && beat_hold;
  assign a_hold      = a_valid && b_hold;
  assign depth_stall = a_hold;

  // stage a: span and clamped offset
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (!a_hold) begin
      a_valid <= depth_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!a_hold) begin
      a_span   <= span;
      a_offset <= offset;
    end
  end

  // stage b: scaled dividend and divisor aligned to the top quotient bit
  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
    end else if (!b_hold) begin
      beat_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!b_hold) begin
      beat.rem <= {{HUE_BITS{1'b0}}, a_offset} * REM_BITS'(HUE_MAX);
      beat.dvs <= REM_BITS'(a_span) << (HUE_BITS - 1);
      beat.quo <= '0;
    end
  end

endmodule

// ----- rtl/dhc_div_cell.sv -----
module dhc_div_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  dhc_pkg::div_beat_t in_beat,
  output logic               in_hold,
  output logic               out_valid,
  output dhc_pkg::div_beat_t out_beat,
  input  logic               out_hold
);
  import dhc_pkg::*;

  logic      take;
  div_beat_t nxt;

  // one restoring quotient bit per cell
  always_comb begin
    take     = in_beat.rem >= in_beat.dvs;
    nxt.rem  = take ? (in_beat.rem - in_beat.dvs) : in_beat.rem;
    nxt.dvs  = in_beat.dvs >> 1;
    nxt.quo  = {in_beat.quo[HUE_BITS-2:0], take};
  end

  assign in_hold = out_valid && out_hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_hold) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_hold) begin
      out_beat <= nxt;
    end
  end

endmodule

// ----- rtl/dhc_color.sv -----
module dhc_color (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [dhc_pkg::HUE_BITS-1:0] in_hue,
  output logic                         in_hold,
  output logic                         pixel_valid,
  input  logic                         pixel_stall,
  output logic [7:0]                   red,
  output logic [7:0]                   green,
  output logic [7:0]                   blue,
  output logic [dhc_pkg::HUE_BITS-1:0] hue_level
);
  import dhc_pkg::*;

  typedef enum logic [2:0] {
    SEC_RED_GREEN_UP  = 3'd0,
    SEC_RED_DOWN      = 3'd1,
    SEC_BLUE_UP       = 3'd2,
    SEC_GREEN_DOWN    = 3'd3,
    SEC_RED_UP        = 3'd4,
    SEC_BLUE_DOWN     = 3'd5
  } sector_t;

  logic [2:0]          count;
  sector_t             sector;
  logic [HUE_BITS-1:0] base;
  logic [7:0]          step;
  logic [7:0]          r_n;
  logic [7:0]          g_n;
  logic [7:0]          b_n;

  // sector is the number of ramp boundaries at or below the hue
  always_comb begin
    count = '0;
    for (int k = 1; k < 6; k++) begin
      if (in_hue >= HUE_BITS'(RAMP * k)) begin
        count = count + 3'd1;
      end
    end
    base   = HUE_BITS'(count) * HUE_BITS'(RAMP);
    step   = 8'(in_hue - base);
    sector = sector_t'(count);
    case (sector)
      SEC_RED_GREEN_UP: begin r_n = 8'hff;        g_n = step;         b_n = 8'h00; end
      SEC_RED_DOWN:     begin r_n = 8'hff - step; g_n = 8'hff;        b_n = 8'h00; end
      SEC_BLUE_UP:      begin r_n = 8'h00;        g_n = 8'hff;        b_n = step; end
      SEC_GREEN_DOWN:   begin r_n = 8'h00;        g_n = 8'hff - step; b_n = 8'hff; end
      SEC_RED_UP:       begin r_n = step;         g_n = 8'h00;        b_n = 8'hff; end
      SEC_BLUE_DOWN:    begin r_n = 8'hff;        g_n = 8'h00;        b_n = 8'hff - step; end
      default:          begin r_n = 8'hff;        g_n = 8'h00;        b_n = 8'h00; end
    endcase
  end

  assign in_hold = pixel_valid && pixel_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (!in_hold) begin
      pixel_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_hold) begin
      red       <= r_n;
      green     <= g_n;
      blue      <= b_n;
      hue_level <= in_hue;
    end
  end

endmodule

// ----- rtl/depth_hue_colorizer_unit.sv -----
// depth hue colorizer: one depth sample in, one fully saturated rgb pixel out
// input channel: depth with depth_valid/depth_stall, a beat moves when valid is
//   high and stall is low
// output channel: red, green, blue, hue_level with pixel_valid/pixel_stall;
//   alpha is always 255 and is not carried
// min_depth (address 0) and max_depth (address 4) are set over the apb port,
//   only while no beat is in flight; the user must keep to this, the block does not enforce it
// the pipeline is span/clamp, scale by 1529, 11 divider cells (one
//   quotient bit each), then the color ramp register
// throughput is one pixel per clock while pixel_stall is low; every stage holds
//   its own beat so the chain keeps flowing
// a stall at the output freezes the last stage and each full stage directly behind
//   it; bubbles ahead fill up, and depth_stall rises once the first stage is full and blocked
// reset clears all valid bits and sets min_depth to 0, max_depth to all ones
`include "depth_hue_colorizer_unit_macros.svh"

module depth_hue_colorizer_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dhc_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [dhc_pkg::DATA_BITS-1:0]  pwdata,
  output logic [dhc_pkg::DATA_BITS-1:0]  prdata,
  output logic                           pready,
  input  logic                           depth_valid,
  input  logic [dhc_pkg::DEPTH_BITS-1:0] depth,
  output logic                           depth_stall,
  output logic                           pixel_valid,
  input  logic                           pixel_stall,
  output logic [7:0]                     red,
  output logic [7:0]                     green,
  output logic [7:0]                     blue,
  output logic [dhc_pkg::HUE_BITS-1:0]   hue_level
);
  import dhc_pkg::*;

  logic [DEPTH_BITS-1:0] min_depth;
  logic [DEPTH_BITS-1:0] max_depth;
  reg_idx_t              reg_sel;
  logic                  wr_en;

  logic      chain_valid [0:DIV_CELLS];
  div_beat_t chain_beat  [0:DIV_CELLS];
  logic      chain_hold  [0:DIV_CELLS];

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_depth <= '0;
      max_depth <= '1;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_MIN_DEPTH: min_depth <= pwdata[DEPTH_BITS-1:0];
        REG_MAX_DEPTH: max_depth <= pwdata[DEPTH_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_MIN_DEPTH: prdata = DATA_BITS'(min_depth);
      REG_MAX_DEPTH: prdata = DATA_BITS'(max_depth);
      default:       prdata = '0;
    endcase
  end

  dhc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .min_depth   (min_depth),
    .max_depth   (max_depth),
    .depth_valid (depth_valid),
    .depth       (depth),
    .depth_stall (depth_stall),
    .beat_valid  (chain_valid[0]),
    .beat        (chain_beat[0]),
    .beat_hold   (chain_hold[0])
  );

  for (genvar k = 0; k < DIV_CELLS; k++) begin : g_cell
    dhc_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[k]),
      .in_beat   (chain_beat[k]),
      .in_hold   (chain_hold[k]),
      .out_valid (chain_valid[k+1]),
      .out_beat  (chain_beat[k+1]),
      .out_hold  (chain_hold[k+1])
    );
  end

  dhc_color u_color (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (chain_valid[DIV_CELLS]),
    .in_hue      (chain_beat[DIV_CELLS].quo),
    .in_hold     (chain_hold[DIV_CELLS]),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .hue_level   (hue_level)
  );

  `DHC_ASSERT(a_hue_bound, clk, rst, pixel_valid, hue_level <= HUE_BITS'(HUE_MAX), "hue above 1529")
  `DHC_ASSERT(a_first_ramp, clk, rst, pixel_valid && (hue_level < HUE_BITS'(RAMP)), (red == 8'hff) && (blue == 8'h00) && (green == hue_level[7:0]), "first ramp color wrong")
  `DHC_ASSERT(a_stall_full, clk, rst, depth_stall, chain_valid[0] && pixel_valid && pixel_stall, "input stalled with room in the chain")
  `DHC_ASSERT_NEXT(a_div_done, clk, rst, chain_valid[DIV_CELLS] && !chain_hold[DIV_CELLS], pixel_valid, "divider beat lost before color stage")

endmodule
